// ===== sv/ordered_list_engine_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Ordered list engine assertion macros
// Shared concurrent assertion forms, clocked by i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_ENGINE_UNIT_MACROS_SVH
`define ORDERED_LIST_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication.
`define OLE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define OLE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ole_pkg.sv =====
// ----------------------------------------------------------------------------
// Ordered list engine package
// Item types, command and status codes, and cell control codes.
// ----------------------------------------------------------------------------
package ole_pkg;

    localparam int OLE_CAPACITY   = 16;
    localparam int OLE_VALUE_BITS = 32;

    localparam int CMD_BITS   = 3;
    localparam int POS_BITS   = 5;
    localparam int DATA_BITS  = 32;
    localparam int STAT_BITS  = 2;
    localparam int FPOS_BITS  = 4;
    localparam int COUNT_BITS = 5;

    localparam logic [CMD_BITS-1:0] CMD_INS_HEAD = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_INS_TAIL = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_INS_AT   = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_GET      = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_SEARCH   = 3'd4;
    localparam logic [CMD_BITS-1:0] CMD_RM_HEAD  = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_RM_TAIL  = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_RM_AT    = 3'd7;

    localparam logic [STAT_BITS-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_IGNORED   = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [STAT_BITS-1:0] ST_FULL      = 2'd3;

    typedef logic [1:0] t_cell_mode;
    localparam t_cell_mode CELL_HOLD   = 2'd0;
    localparam t_cell_mode CELL_INSERT = 2'd1;
    localparam t_cell_mode CELL_REMOVE = 2'd2;
    localparam t_cell_mode CELL_ROTATE = 2'd3;

    typedef struct packed {
        logic [CMD_BITS-1:0]         command;
        logic [POS_BITS-1:0]         position;
        logic signed [DATA_BITS-1:0] value;
    } t_command;

    typedef struct packed {
        logic [STAT_BITS-1:0]        status;
        logic signed [DATA_BITS-1:0] read_value;
        logic [FPOS_BITS-1:0]        found_position;
        logic [COUNT_BITS-1:0]       item_count;
    } t_result;

    typedef struct packed {
        logic busy;
        logic rotate;
        logic done;
    } t_scan_status;

endpackage

// ===== sv/ole_cell.sv =====
// ----------------------------------------------------------------------------
// Ordered list engine cell
// One list entry; holds, loads, or takes the entry of a neighbor.
// ----------------------------------------------------------------------------
module ole_cell import ole_pkg::*; #(
    parameter int CAPACITY   = OLE_CAPACITY,
    parameter int VALUE_BITS = OLE_VALUE_BITS,
    parameter int INDEX      = 0
) (
    input  logic                          i_clk,
    input  t_cell_mode                    i_mode,
    input  logic [$clog2(CAPACITY)-1:0]   i_pos,
    input  logic [VALUE_BITS-1:0]         i_load,
    input  logic [VALUE_BITS-1:0]         i_up,
    input  logic [VALUE_BITS-1:0]         i_dn,
    output logic [VALUE_BITS-1:0]         o_q
);

    localparam int IW = $clog2(CAPACITY);
    localparam logic [IW-1:0] MY_INDEX = IW'(INDEX);

    logic [VALUE_BITS-1:0] r_q;
    logic [VALUE_BITS-1:0] n_q;

    always_comb begin
        n_q = r_q;
        unique case (i_mode)
            CELL_HOLD: begin
                n_q = r_q;
            end
            CELL_INSERT: begin
                // Entries above the insert point move up by one place.
                priority if (MY_INDEX > i_pos) begin
                    n_q = i_up;
                end else if (MY_INDEX == i_pos) begin
                    n_q = i_load;
                end else begin
                    n_q = r_q;
                end
            end
            CELL_REMOVE: begin
                if (MY_INDEX >= i_pos) begin
                    n_q = i_dn;
                end
            end
            CELL_ROTATE: begin
                n_q = i_dn;
            end
            default: begin
                n_q = r_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

    assign o_q = r_q;

endmodule

// ===== sv/ole_scan.sv =====
// ----------------------------------------------------------------------------
// Ordered list engine scan sequencer
// Walks the list past the head cell for get and search commands.
// ----------------------------------------------------------------------------
module ole_scan import ole_pkg::*; #(
    parameter int CAPACITY   = OLE_CAPACITY,
    parameter int VALUE_BITS = OLE_VALUE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_search,
    input  logic [$clog2(CAPACITY)-1:0]     i_pos,
    input  logic [VALUE_BITS-1:0]           i_value,
    input  logic [$clog2(CAPACITY+1)-1:0]   i_count,
    input  logic [VALUE_BITS-1:0]           i_head,
    output t_scan_status                    o_stat,
    output t_result                         o_res
);

`include "ordered_list_engine_unit_macros.svh"

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [IW-1:0] LAST_STEP = IW'(CAPACITY - 1);

    logic                  r_active;
    logic                  r_done;
    logic [IW-1:0]         r_step;
    logic                  r_search;
    logic [IW-1:0]         r_pos;
    logic [VALUE_BITS-1:0] r_val;
    logic                  r_found;
    logic [IW-1:0]         r_fpos;
    logic [VALUE_BITS-1:0] r_rd;
    t_result               r_res;

    logic                  n_found;
    logic [IW-1:0]         n_fpos;
    logic [VALUE_BITS-1:0] n_rd;
    logic                  hit;
    logic                  take;
    logic                  last;
    t_result               fin_res;

    // The head cell holds the entry at position r_step during each step.
    always_comb begin
        hit     = r_search && !r_found && (CW'(r_step) < i_count) && (i_head == r_val);
        take    = !r_search && (r_step == r_pos);
        last    = (r_step == LAST_STEP);
        n_found = r_found | hit;
        n_fpos  = hit ? r_step : r_fpos;
        n_rd    = take ? i_head : r_rd;

        fin_res.item_count = COUNT_BITS'(i_count);
        if (r_search) begin
            fin_res.status         = n_found ? ST_DONE : ST_NOT_FOUND;
            fin_res.read_value     = '0;
            fin_res.found_position = n_found ? FPOS_BITS'(n_fpos) : '0;
        end else begin
            fin_res.status         = ST_DONE;
            fin_res.read_value     = DATA_BITS'($signed(n_rd));
            fin_res.found_position = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_done   <= 1'b0;
            r_step   <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_step   <= '0;
            end else if (r_active) begin
                r_step <= r_step + IW'(1);
                if (last) begin
                    r_active <= 1'b0;
                    r_done   <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_search <= i_search;
            r_pos    <= i_pos;
            r_val    <= i_value;
            r_found  <= 1'b0;
        end else if (r_active) begin
            r_found <= n_found;
            r_fpos  <= n_fpos;
            r_rd    <= n_rd;
            if (last) begin
                r_res <= fin_res;
            end
        end
    end

    assign o_stat.busy   = r_active | r_done;
    assign o_stat.rotate = r_active;
    assign o_stat.done   = r_done;
    assign o_res         = r_res;

    `OLE_ASSERT_NEXT(a_scan_ends, r_active && last && !i_start, r_done && !r_active, "scan did not finish after its last step")
    `OLE_ASSERT_NOW(a_done_idle, r_done, !r_active, "scan result flagged while still rotating")
    `OLE_ASSERT_NEXT(a_done_pulse, r_done && !i_start, !r_done, "scan result flagged for more than one cycle")

endmodule

// ===== sv/ordered_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Ordered list engine
// Bounded ordered list of signed values kept in a chain of entry cells.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  Handshake                  Payload
//  command   in   start high, busy low       i_cmd    (t_command)
//  result    out  o_valid, one cycle strobe  o_result (t_result)
//
// Inserts, removes and any command that is rejected post their result in the
// next cycle, and a new item may be started then.
// A get in range and every search make one full rotation of the cell chain
// past the head cell, after which the scan flags done and the result is
// registered for posting; busy stays high until the result strobe.
// Reset clears the entry count, the result strobe and the scan state; the cells need no clearing.
// The receiver cannot stall; each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module ordered_list_engine_unit import ole_pkg::*; #(
    parameter int CAPACITY   = OLE_CAPACITY,
    parameter int VALUE_BITS = OLE_VALUE_BITS
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    output logic     busy,
    input  t_command i_cmd,
    output logic     o_valid,
    output t_result  o_result
);

`include "ordered_list_engine_unit_macros.svh"

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_BITS) ? CW : POS_BITS;
    localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

    // List length and the registered result.
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic          r_valid;
    t_result       r_result;

    logic                  accept;
    logic                  full;
    logic [CMPW-1:0]       pos_w;
    logic [CMPW-1:0]       cnt_w;
    logic [CW-1:0]         cnt_m1;
    logic [VALUE_BITS-1:0] val_st;
    t_cell_mode            cell_mode;
    logic [IW-1:0]         cell_pos;
    logic                  scan_start;
    logic                  scan_search;
    logic [IW-1:0]         scan_pos;
    logic [STAT_BITS-1:0]  imm_status;
    t_result               imm_res;
    t_scan_status          scan_stat;
    t_result               scan_res;

    logic [VALUE_BITS-1:0] w_q [CAPACITY];

    assign accept = start && !busy;
    assign busy   = scan_stat.busy;

    always_comb begin
        full     = (r_count >= FULL_COUNT);
        pos_w    = CMPW'(i_cmd.position);
        cnt_w    = CMPW'(r_count);
        cnt_m1   = r_count - CW'(1);
        // The input value is sign-extended or cut to the stored width.
        val_st   = VALUE_BITS'(i_cmd.value);
        scan_pos = pos_w[IW-1:0];

        n_count     = r_count;
        cell_mode   = CELL_HOLD;
        cell_pos    = pos_w[IW-1:0];
        scan_start  = 1'b0;
        scan_search = 1'b0;
        imm_status  = ST_DONE;

        if (scan_stat.rotate) begin
            cell_mode = CELL_ROTATE;
        end else if (accept) begin
            unique case (i_cmd.command)
                CMD_INS_HEAD: begin
                    if (full) begin
                        imm_status = ST_FULL;
                    end else begin
                        cell_mode = CELL_INSERT;
                        cell_pos  = '0;
                        n_count   = r_count + CW'(1);
                    end
                end
                CMD_INS_TAIL: begin
                    if (full) begin
                        imm_status = ST_FULL;
                    end else begin
                        cell_mode = CELL_INSERT;
                        cell_pos  = r_count[IW-1:0];
                        n_count   = r_count + CW'(1);
                    end
                end
                CMD_INS_AT: begin
                    // The range check takes precedence over the full check.
                    priority if (pos_w > cnt_w) begin
                        imm_status = ST_IGNORED;
                    end else if (full) begin
                        imm_status = ST_FULL;
                    end else begin
                        cell_mode = CELL_INSERT;
                        n_count   = r_count + CW'(1);
                    end
                end
                CMD_GET: begin
                    if (pos_w < cnt_w) begin
                        scan_start = 1'b1;
                    end else begin
                        imm_status = ST_IGNORED;
                    end
                end
                CMD_SEARCH: begin
                    scan_start  = 1'b1;
                    scan_search = 1'b1;
                end
                CMD_RM_HEAD: begin
                    if (r_count == '0) begin
                        imm_status = ST_IGNORED;
                    end else begin
                        cell_mode = CELL_REMOVE;
                        cell_pos  = '0;
                        n_count   = cnt_m1;
                    end
                end
                CMD_RM_TAIL: begin
                    if (r_count == '0) begin
                        imm_status = ST_IGNORED;
                    end else begin
                        cell_mode = CELL_REMOVE;
                        cell_pos  = cnt_m1[IW-1:0];
                        n_count   = cnt_m1;
                    end
                end
                CMD_RM_AT: begin
                    if (pos_w >= cnt_w) begin
                        imm_status = ST_IGNORED;
                    end else begin
                        cell_mode = CELL_REMOVE;
                        n_count   = cnt_m1;
                    end
                end
                default: begin
                    imm_status = ST_IGNORED;
                end
            endcase
        end

        imm_res.status         = imm_status;
        imm_res.read_value     = '0;
        imm_res.found_position = '0;
        imm_res.item_count     = COUNT_BITS'(n_count);
    end

    // The chain: each cell sees its lower neighbor for inserts and its upper
    // neighbor for removes; the top cell wraps to the head so that a full
    // rotation restores the list.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        localparam int UP_IDX = (g == 0) ? 0 : g - 1;
        localparam int DN_IDX = (g + 1) % CAPACITY;

        ole_cell #(
            .CAPACITY   (CAPACITY),
            .VALUE_BITS (VALUE_BITS),
            .INDEX      (g)
        ) u_cell (
            .i_clk  (i_clk),
            .i_mode (cell_mode),
            .i_pos  (cell_pos),
            .i_load (val_st),
            .i_up   (w_q[UP_IDX]),
            .i_dn   (w_q[DN_IDX]),
            .o_q    (w_q[g])
        );
    end

    ole_scan #(
        .CAPACITY   (CAPACITY),
        .VALUE_BITS (VALUE_BITS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (scan_start),
        .i_search (scan_search),
        .i_pos    (scan_pos),
        .i_value  (val_st),
        .i_count  (r_count),
        .i_head   (w_q[0]),
        .o_stat   (scan_stat),
        .o_res    (scan_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_valid <= (accept && !scan_start) || scan_stat.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (scan_stat.done) begin
            r_result <= scan_res;
        end else begin
            r_result <= imm_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    `OLE_ASSERT_NOW(a_count_max, 1'b1, r_count <= FULL_COUNT, "entry count above capacity")
    `OLE_ASSERT_NEXT(a_quick_result, accept && !scan_start, o_valid, "one-cycle item gave no result")
    `OLE_ASSERT_NOW(a_result_count, o_valid, o_result.item_count == COUNT_BITS'(r_count), "result count differs from the list length")

endmodule
